// ----- rtl/pwfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwfd_pkg
// Shared widths, register map, reset values and types of the pulse width
// frame decoder.
// ----------------------------------------------------------------------------
package pwfd_pkg;

	localparam int DATA_BITS  = 32;
	localparam int COUNT_BITS = 16;
	localparam int SAMPLE_W   = 16;
	localparam int PERIOD_W   = SAMPLE_W + 1;
	localparam int THRESH_W   = 17;
	localparam int PHASE_W    = 16;
	localparam int FRAME_W    = 32;
	localparam int APB_DATA_W = 32;
	localparam int ADDR_W     = 5;
	localparam int IDX_W      = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_STOP_GAP_MIN       = 3'd0,
		REG_CONSOLE_PERIOD_MIN = 3'd1,
		REG_CONSOLE_PERIOD_MAX = 3'd2,
		REG_DEVICE_PERIOD_MIN  = 3'd3,
		REG_DEVICE_PERIOD_MAX  = 3'd4,
		REG_PHASE_MIN          = 3'd5,
		REG_PHASE_MAX          = 3'd6
	} reg_idx_t;

	localparam logic [THRESH_W-1:0] RST_STOP_GAP_MIN       = 17'd112;
	localparam logic [THRESH_W-1:0] RST_CONSOLE_PERIOD_MIN = 17'd72;
	localparam logic [THRESH_W-1:0] RST_CONSOLE_PERIOD_MAX = 17'd80;
	localparam logic [THRESH_W-1:0] RST_DEVICE_PERIOD_MIN  = 17'd56;
	localparam logic [THRESH_W-1:0] RST_DEVICE_PERIOD_MAX  = 17'd64;
	localparam logic [PHASE_W-1:0]  RST_PHASE_MIN          = 16'd8;
	localparam logic [PHASE_W-1:0]  RST_PHASE_MAX          = 16'd24;

	typedef struct packed {
		logic [THRESH_W-1:0] stop_gap_min;
		logic [THRESH_W-1:0] console_period_min;
		logic [THRESH_W-1:0] console_period_max;
		logic [THRESH_W-1:0] device_period_min;
		logic [THRESH_W-1:0] device_period_max;
		logic [PHASE_W-1:0]  phase_min;
		logic [PHASE_W-1:0]  phase_max;
	} cfg_t;

	typedef struct packed {
		logic long_gap;
		logic console_hit;
		logic device_hit;
		logic phase_ok;
		logic bit_val;
	} cell_class_t;

endpackage

// ----- rtl/pwfd_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwfd_cfg_regs
// APB register file holding the timing thresholds.
// ----------------------------------------------------------------------------
module pwfd_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pwfd_pkg::ADDR_W-1:0]         paddr,
	input  logic [pwfd_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [pwfd_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output pwfd_pkg::cfg_t                      cfg
);

	pwfd_pkg::cfg_t     cfg_q;
	pwfd_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = pwfd_pkg::reg_idx_t'(paddr[pwfd_pkg::ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_gap_min       <= pwfd_pkg::RST_STOP_GAP_MIN;
			cfg_q.console_period_min <= pwfd_pkg::RST_CONSOLE_PERIOD_MIN;
			cfg_q.console_period_max <= pwfd_pkg::RST_CONSOLE_PERIOD_MAX;
			cfg_q.device_period_min  <= pwfd_pkg::RST_DEVICE_PERIOD_MIN;
			cfg_q.device_period_max  <= pwfd_pkg::RST_DEVICE_PERIOD_MAX;
			cfg_q.phase_min          <= pwfd_pkg::RST_PHASE_MIN;
			cfg_q.phase_max          <= pwfd_pkg::RST_PHASE_MAX;
		end else if (wr_en) begin
			unique case (idx)
				pwfd_pkg::REG_STOP_GAP_MIN:
					cfg_q.stop_gap_min <= pwdata[pwfd_pkg::THRESH_W-1:0];
				pwfd_pkg::REG_CONSOLE_PERIOD_MIN:
					cfg_q.console_period_min <= pwdata[pwfd_pkg::THRESH_W-1:0];
				pwfd_pkg::REG_CONSOLE_PERIOD_MAX:
					cfg_q.console_period_max <= pwdata[pwfd_pkg::THRESH_W-1:0];
				pwfd_pkg::REG_DEVICE_PERIOD_MIN:
					cfg_q.device_period_min <= pwdata[pwfd_pkg::THRESH_W-1:0];
				pwfd_pkg::REG_DEVICE_PERIOD_MAX:
					cfg_q.device_period_max <= pwdata[pwfd_pkg::THRESH_W-1:0];
				pwfd_pkg::REG_PHASE_MIN:
					cfg_q.phase_min <= pwdata[pwfd_pkg::PHASE_W-1:0];
				pwfd_pkg::REG_PHASE_MAX:
					cfg_q.phase_max <= pwdata[pwfd_pkg::PHASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			pwfd_pkg::REG_STOP_GAP_MIN:
				prdata = pwfd_pkg::APB_DATA_W'(cfg_q.stop_gap_min);
			pwfd_pkg::REG_CONSOLE_PERIOD_MIN:
				prdata = pwfd_pkg::APB_DATA_W'(cfg_q.console_period_min);
			pwfd_pkg::REG_CONSOLE_PERIOD_MAX:
				prdata = pwfd_pkg::APB_DATA_W'(cfg_q.console_period_max);
			pwfd_pkg::REG_DEVICE_PERIOD_MIN:
				prdata = pwfd_pkg::APB_DATA_W'(cfg_q.device_period_min);
			pwfd_pkg::REG_DEVICE_PERIOD_MAX:
				prdata = pwfd_pkg::APB_DATA_W'(cfg_q.device_period_max);
			pwfd_pkg::REG_PHASE_MIN:
				prdata = pwfd_pkg::APB_DATA_W'(cfg_q.phase_min);
			pwfd_pkg::REG_PHASE_MAX:
				prdata = pwfd_pkg::APB_DATA_W'(cfg_q.phase_max);
			default: prdata = '0;
		endcase
	end

endmodule

// ----- rtl/pwfd_cell_class.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwfd_cell_class
// Classifies one bit cell against the period and phase windows.
// ----------------------------------------------------------------------------
module pwfd_cell_class (
	input  logic [pwfd_pkg::PERIOD_W-1:0] period,
	input  logic [pwfd_pkg::SAMPLE_W-1:0] low_samples,
	input  logic [pwfd_pkg::SAMPLE_W-1:0] high_samples,
	input  pwfd_pkg::cfg_t                cfg,
	output pwfd_pkg::cell_class_t         cls
);

	logic hi_fit;
	logic lo_fit;

	assign hi_fit = (high_samples >= cfg.phase_min) && (high_samples <= cfg.phase_max);
	assign lo_fit = (low_samples >= cfg.phase_min) && (low_samples <= cfg.phase_max);

	always_comb begin
		cls.long_gap    = period > cfg.stop_gap_min;
		cls.console_hit = (period >= cfg.console_period_min) &&
			(period <= cfg.console_period_max);
		cls.device_hit  = (period >= cfg.device_period_min) &&
			(period <= cfg.device_period_max);
		cls.phase_ok    = hi_fit | lo_fit;
		// short high phase wins and decodes as zero
		cls.bit_val     = lo_fit & ~hi_fit;
	end

endmodule

// ----- rtl/pwfd_frame_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwfd_frame_core
// Frame state (bit count, marks, shift word) and the result register.
// ----------------------------------------------------------------------------
module pwfd_frame_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cell_valid,
	input  pwfd_pkg::cell_class_t            cls,
	output logic                             advance,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pwfd_pkg::FRAME_W-1:0]     m_tdata,
	output logic                             m_tuser
);

	logic [pwfd_pkg::COUNT_BITS-1:0] bits_q;
	logic [pwfd_pkg::COUNT_BITS-1:0] before_q;
	logic                            inv_q;
	logic                            ctrl_q;
	logic [pwfd_pkg::DATA_BITS-1:0]  word_q;

	logic                            out_valid_q;
	logic [pwfd_pkg::FRAME_W-1:0]    out_data_q;
	logic                            out_ctrl_q;

	logic                            fresh;
	logic [pwfd_pkg::COUNT_BITS-1:0] before_eff;
	logic                            inv_eff;
	logic                            ctrl_eff;
	logic [pwfd_pkg::DATA_BITS-1:0]  word_eff;
	logic                            stop;
	logic                            emit;
	logic [pwfd_pkg::COUNT_BITS-1:0] bits_inc;
	logic                            inv_nx;
	logic                            ctrl_nx;
	logic [pwfd_pkg::FRAME_W-1:0]    frame_word;

	logic [pwfd_pkg::COUNT_BITS-1:0] bits_d;
	logic [pwfd_pkg::COUNT_BITS-1:0] before_d;
	logic                            inv_d;
	logic                            ctrl_d;
	logic [pwfd_pkg::DATA_BITS-1:0]  word_d;

	assign advance = ~out_valid_q | m_tready;

	// a zero count starts a new frame: previous marks and word are gone
	assign fresh      = bits_q == '0;
	assign before_eff = fresh ? '0 : before_q;
	assign inv_eff    = fresh ? 1'b0 : inv_q;
	assign ctrl_eff   = fresh ? 1'b0 : ctrl_q;
	assign word_eff   = fresh ? '0 : word_q;

	assign stop = (bits_q[2:0] == 3'd0) && cls.long_gap;
	assign emit = stop & ~inv_eff;

	assign bits_inc = bits_q + pwfd_pkg::COUNT_BITS'(cls.console_hit) +
		pwfd_pkg::COUNT_BITS'(cls.device_hit);
	assign inv_nx  = inv_eff | ((cls.console_hit | cls.device_hit) & ~cls.phase_ok);
	assign ctrl_nx = ctrl_eff | cls.device_hit;

	generate
		if (pwfd_pkg::DATA_BITS >= pwfd_pkg::FRAME_W) begin : g_frame_trunc
			assign frame_word = word_eff[pwfd_pkg::FRAME_W-1:0];
		end else begin : g_frame_ext
			assign frame_word = {{(pwfd_pkg::FRAME_W - pwfd_pkg::DATA_BITS){1'b0}}, word_eff};
		end
	endgenerate

	always_comb begin
		bits_d   = bits_q;
		before_d = before_eff;
		inv_d    = inv_eff;
		ctrl_d   = ctrl_eff;
		word_d   = word_eff;
		priority if (stop) begin
			bits_d = '0;
		end else if (bits_inc == '0) begin
			bits_d = '0;
			inv_d  = inv_nx;
			ctrl_d = ctrl_nx;
		end else begin
			// no new bit since last shift: drop the frame
			bits_d   = (bits_inc == before_eff) ? '0 : bits_inc;
			before_d = (bits_inc == before_eff) ? '0 : bits_inc;
			inv_d    = inv_nx;
			ctrl_d   = ctrl_nx;
			word_d   = {word_eff[pwfd_pkg::DATA_BITS-2:0], cls.bit_val};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q      <= '0;
			before_q    <= '0;
			inv_q       <= 1'b0;
			ctrl_q      <= 1'b0;
			word_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= cell_valid & emit;
			if (cell_valid) begin
				bits_q   <= bits_d;
				before_q <= before_d;
				inv_q    <= inv_d;
				ctrl_q   <= ctrl_d;
				word_q   <= word_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cell_valid && emit) begin
			out_data_q <= frame_word;
			out_ctrl_q <= ctrl_eff;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_ctrl_q;

endmodule

// ----- rtl/pulse_width_frame_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_frame_decoder_unit
// Decodes bit cells given as low and high sample counts into frames.
//
//   channel  dir  payload
//   s_*      in   tdata[15:0] low_samples, tdata[31:16] high_samples
//   m_*      out  tdata[31:0] frame_data, tuser[0] from_controller
//   apb      in   7 threshold registers at byte address 4*i
//
// one bit cell per cycle while the result side does not stall; a cell is
// taken into the input register, then its result into the result register
// a held result stalls the result register and, once the input register is
// full too, drops s_tready
// reset restores the default thresholds and clears the frame state
// ----------------------------------------------------------------------------
module pulse_width_frame_decoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [31:0]                     s_tdata,   // low_samples, high_samples
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pwfd_pkg::FRAME_W-1:0]    m_tdata,   // frame_data
	output logic                            m_tuser,   // from_controller
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pwfd_pkg::ADDR_W-1:0]     paddr,
	input  logic [pwfd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [pwfd_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	pwfd_pkg::cfg_t                 cfg;
	pwfd_pkg::cell_class_t          cls;
	logic                           advance;

	logic                           valid_s1;
	logic [pwfd_pkg::SAMPLE_W-1:0]  low_s1;
	logic [pwfd_pkg::SAMPLE_W-1:0]  high_s1;
	logic [pwfd_pkg::PERIOD_W-1:0]  period_s1;

	logic [pwfd_pkg::SAMPLE_W-1:0]  low_in;
	logic [pwfd_pkg::SAMPLE_W-1:0]  high_in;

	assign low_in   = s_tdata[pwfd_pkg::SAMPLE_W-1:0];
	assign high_in  = s_tdata[2*pwfd_pkg::SAMPLE_W-1:pwfd_pkg::SAMPLE_W];
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			low_s1    <= low_in;
			high_s1   <= high_in;
			period_s1 <= {1'b0, low_in} + {1'b0, high_in};
		end
	end

	pwfd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pwfd_cell_class u_class (
		.period       (period_s1),
		.low_samples  (low_s1),
		.high_samples (high_s1),
		.cfg          (cfg),
		.cls          (cls)
	);

	pwfd_frame_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (valid_s1),
		.cls        (cls),
		.advance    (advance),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ----- rtl/pwfd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwfd_checker
// Port-level checks of the pulse width frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pwfd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [pwfd_pkg::FRAME_W-1:0]    m_tdata,
	input logic                            m_tuser,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [pwfd_pkg::ADDR_W-1:0]     paddr,
	input logic [pwfd_pkg::APB_DATA_W-1:0] pwdata,
	input logic [pwfd_pkg::APB_DATA_W-1:0] prdata
);

	// a stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// a result beat only leaves through a handshake
	a_out_leave: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result beat dropped without handshake");

	// with the result register empty the input side never stalls
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// stop gap threshold reads back what was written
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite &&
		paddr[pwfd_pkg::ADDR_W-1:2] == pwfd_pkg::REG_STOP_GAP_MIN
		##1 (!pwrite && paddr == $past(paddr))
		|-> prdata[pwfd_pkg::THRESH_W-1:0] == $past(pwdata[pwfd_pkg::THRESH_W-1:0]))
		else $error("threshold readback mismatch");

endmodule

bind pulse_width_frame_decoder_unit pwfd_checker u_pwfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata)
);
